// ===== design/tvpd_pkg.sv =====
`timescale 1ns / 1ps

package tvpd_pkg;

   // packet and frame geometry
   localparam int unsigned PACKET_BYTES = 164;
   localparam int unsigned FRAME_ROWS   = 60;
   localparam int unsigned HEADER_BYTES = 4;

   localparam int unsigned POS_BITS = 8;
   localparam int unsigned ROW_BITS = 6;
   localparam int unsigned COL_BITS = 7;
   localparam int unsigned CNT_BITS = 10;
   localparam int unsigned PIX_BITS = 16;
   localparam int unsigned BYTE_BITS = 8;

   // last byte position that completes a pixel pair
   localparam logic [POS_BITS-1:0] LAST_PIXEL_POS =
      POS_BITS'(3 + 2 * ((PACKET_BYTES - HEADER_BYTES) / 2));
   localparam logic [POS_BITS-1:0] LAST_BYTE_POS  = POS_BITS'(PACKET_BYTES - 1);
   localparam logic [POS_BITS-1:0] ROW_BYTE_POS   = POS_BITS'(1);
   localparam logic [POS_BITS-1:0] FIRST_PIX_POS  = POS_BITS'(HEADER_BYTES);
   localparam logic [ROW_BITS-1:0] LAST_ROW       = ROW_BITS'(FRAME_ROWS - 1);
   localparam logic [CNT_BITS-1:0] CNT_MAX        = '1;

   // register map
   localparam int unsigned CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TIMEOUT_LIMIT = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WARN_LIMIT    = 1'd1;
   localparam logic [CNT_BITS-1:0] TIMEOUT_LIMIT_RESET = CNT_BITS'(750);
   localparam logic [CNT_BITS-1:0] WARN_LIMIT_RESET    = CNT_BITS'(30);

   // one result
   typedef struct packed {
      logic                write_enable;
      logic [ROW_BITS-1:0] pixel_row;
      logic [COL_BITS-1:0] pixel_column;
      logic [PIX_BITS-1:0] pixel_value;
      logic                end_of_frame;
      logic                resync_event;
      logic                sync_timeout;
      logic                many_resyncs;
      logic                zero_dropped;
      logic [CNT_BITS-1:0] resync_total;
   } rsp_type;

endpackage

// ===== design/thermal_video_packet_deframer.sv =====
`timescale 1ns / 1ps

// a result is registered in the output register, or the skid slot on a stall
// one byte request per cycle if ready; a pixel result on every second payload byte
// two result slots (output register plus skid) keep requests flowing under short stalls
// reset (synchronous): byte counter, row, resync count and zero stop cleared,
// limits back to 750 (timeout) and 30 (warning), result slots emptied
module thermal_video_packet_deframer import tvpd_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [BYTE_BITS-1:0]      req_rx_byte,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_write_enable,
   output logic [ROW_BITS-1:0]       rsp_pixel_row,
   output logic [COL_BITS-1:0]       rsp_pixel_column,
   output logic [PIX_BITS-1:0]       rsp_pixel_value,
   output logic                      rsp_end_of_frame,
   output logic                      rsp_resync_event,
   output logic                      rsp_sync_timeout,
   output logic                      rsp_many_resyncs,
   output logic                      rsp_zero_dropped,
   output logic [CNT_BITS-1:0]       rsp_resync_total,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CNT_BITS-1:0]       csr_wdata
);

   logic [CNT_BITS-1:0]  timeout_limit_ff, warn_limit_ff;
   logic [POS_BITS-1:0]  byte_pos_ff, byte_pos_in;
   logic [ROW_BITS-1:0]  exp_row_ff, exp_row_in;
   logic                 accepted_ff, accepted_in;
   logic [BYTE_BITS-1:0] high_hold_ff, high_hold_in;
   logic [CNT_BITS-1:0]  resync_cnt_ff, resync_cnt_in;
   logic                 zero_stop_ff, zero_stop_in;

   rsp_type out_ff, skid_ff, result;
   logic    out_valid_ff, skid_valid_ff;
   logic    has_result, req_fire, out_free;

   logic                 row_byte, row_hit, pixel_zone, cnt_sat, zero_mid;
   logic [POS_BITS-1:0]  offset;
   logic [PIX_BITS-1:0]  pix;

   assign csr_ready = 1'b1;
   assign req_ready = !skid_valid_ff;
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !out_valid_ff || rsp_ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_limit_ff <= TIMEOUT_LIMIT_RESET;
         warn_limit_ff    <= WARN_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_TIMEOUT_LIMIT: timeout_limit_ff <= csr_wdata;
            CSR_WARN_LIMIT:    warn_limit_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // per-byte decode
   assign row_byte   = (byte_pos_ff == ROW_BYTE_POS);
   assign row_hit    = (req_rx_byte == {{(BYTE_BITS-ROW_BITS){1'b0}}, exp_row_ff});
   assign pixel_zone = accepted_ff && (byte_pos_ff >= FIRST_PIX_POS)
                       && (byte_pos_ff <= LAST_PIXEL_POS);
   assign offset     = byte_pos_ff - FIRST_PIX_POS;
   assign pix        = {high_hold_ff, req_rx_byte};
   assign cnt_sat    = (resync_cnt_ff == CNT_MAX);

   // next state and result
   always_comb begin
      byte_pos_in   = byte_pos_ff + POS_BITS'(1);
      exp_row_in    = exp_row_ff;
      accepted_in   = accepted_ff;
      high_hold_in  = high_hold_ff;
      resync_cnt_in = resync_cnt_ff;
      zero_mid      = zero_stop_ff;
      has_result    = 1'b0;
      result        = '0;

      if (row_byte) begin
         if (row_hit) begin
            accepted_in = 1'b1;
         end else begin
            accepted_in = 1'b0;
            exp_row_in  = '0;
            zero_mid    = 1'b0;
            if (!cnt_sat) begin
               resync_cnt_in = resync_cnt_ff + CNT_BITS'(1);
            end
            has_result          = 1'b1;
            result.resync_event = 1'b1;
            result.sync_timeout = !cnt_sat && (resync_cnt_in == timeout_limit_ff);
            result.many_resyncs = (resync_cnt_in >= warn_limit_ff);
            result.resync_total = resync_cnt_in;
         end
      end else if (pixel_zone) begin
         if (!offset[0]) begin
            high_hold_in = req_rx_byte;
         end else begin
            if (pix == '0) begin
               zero_mid = 1'b1;
            end
            has_result          = 1'b1;
            result.write_enable = !zero_mid;
            result.pixel_row    = exp_row_ff;
            result.pixel_column = offset[COL_BITS:1];
            result.pixel_value  = pix;
            result.end_of_frame = (exp_row_ff == LAST_ROW) && (byte_pos_ff == LAST_PIXEL_POS);
            result.many_resyncs = (resync_cnt_ff >= warn_limit_ff);
            result.zero_dropped = zero_mid;
            result.resync_total = resync_cnt_ff;
         end
      end

      zero_stop_in = zero_mid;

      // end of packet: advance or wrap the frame
      if (byte_pos_ff >= LAST_BYTE_POS) begin
         if (accepted_ff) begin
            if (exp_row_ff >= LAST_ROW) begin
               exp_row_in    = '0;
               resync_cnt_in = '0;
               zero_stop_in  = 1'b0;
            end else begin
               exp_row_in = exp_row_ff + ROW_BITS'(1);
            end
         end
         accepted_in = 1'b0;
         byte_pos_in = '0;
      end
   end

   // deframer state
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_pos_ff   <= '0;
         exp_row_ff    <= '0;
         accepted_ff   <= 1'b0;
         high_hold_ff  <= '0;
         resync_cnt_ff <= '0;
         zero_stop_ff  <= 1'b0;
      end else if (req_fire) begin
         byte_pos_ff   <= byte_pos_in;
         exp_row_ff    <= exp_row_in;
         accepted_ff   <= accepted_in;
         high_hold_ff  <= high_hold_in;
         resync_cnt_ff <= resync_cnt_in;
         zero_stop_ff  <= zero_stop_in;
      end
   end

   // output register with skid slot
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_free) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (req_fire && has_result) begin
         if (out_free) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (out_free) begin
         out_valid_ff <= 1'b0;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (out_free) begin
            out_ff <= skid_ff;
         end
      end else if (req_fire && has_result) begin
         if (out_free) begin
            out_ff <= result;
         end else begin
            skid_ff <= result;
         end
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_write_enable = out_ff.write_enable;
   assign rsp_pixel_row    = out_ff.pixel_row;
   assign rsp_pixel_column = out_ff.pixel_column;
   assign rsp_pixel_value  = out_ff.pixel_value;
   assign rsp_end_of_frame = out_ff.end_of_frame;
   assign rsp_resync_event = out_ff.resync_event;
   assign rsp_sync_timeout = out_ff.sync_timeout;
   assign rsp_many_resyncs = out_ff.many_resyncs;
   assign rsp_zero_dropped = out_ff.zero_dropped;
   assign rsp_resync_total = out_ff.resync_total;

   // checks
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid slot filled while output register empty");

   a_resync_no_pixel: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_resync_event) |-> (!rsp_write_enable && !rsp_end_of_frame))
      else $error("resync result carries pixel write");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      byte_pos_ff <= LAST_BYTE_POS)
      else $error("byte position beyond packet length");

   a_eof_last_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_end_of_frame) |-> (rsp_pixel_row == LAST_ROW))
      else $error("end of frame outside last row");

endmodule
